[sv/bsc_pkg.sv]
package bsc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_DIV,
    ST_P_SQ,
    ST_P_X1,
    ST_P_X2,
    ST_P_X1B,
    ST_P_X2B,
    ST_P_B4,
    ST_P_B7,
    ST_P_DIV,
    ST_P_T8,
    ST_P_T8C,
    ST_P_X2C,
    ST_DONE
  } state_t;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  localparam int unsigned ALU_STEPS = 32;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_TEMP  = 2'd1;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  localparam logic [2:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [2:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [2:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [2:0] CFG_B1_B2   = 3'd3;
  localparam logic [2:0] CFG_MC_MD   = 3'd4;
  localparam logic [2:0] CFG_OSS     = 3'd5;

  localparam logic [31:0] B6_OFFSET  = 32'd4000;
  localparam logic [31:0] K_T8SQ     = 32'd3038;
  localparam logic [31:0] K_P        = 32'hFFFF_E343;
  localparam logic [31:0] K_ROUND    = 32'd3791;
  localparam logic [31:0] P_SCALE    = 32'd50000;
  localparam logic [31:0] X3_BIAS    = 32'd32768;

endpackage

[sv/bsc_serial_alu.sv]
module bsc_serial_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  bsc_pkg::alu_ctl_t ctl,
  input  logic [31:0]       opa,
  input  logic [31:0]       opb,
  output logic              done,
  output logic [31:0]       result
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  bsc_pkg::alu_op_t  op_r, op_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       x_r, x_nxt;
  logic [31:0]       y_r, y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  always_comb begin
    logic [32:0] sh;
    logic [32:0] diff;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    sh       = {acc_r, y_r[31]};
    diff     = sh - {1'b0, x_r};
    if (ctl.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      if (ctl.op == bsc_pkg::ALU_MUL) begin
        x_nxt = opa;
        y_nxt = opb;
      end else begin
        x_nxt = opb;
        y_nxt = opa;
      end
    end else if (busy_r) begin
      if (op_r == bsc_pkg::ALU_MUL) begin
        if (y_r[0]) begin
          acc_nxt = acc_r + x_r;
        end
        x_nxt = {x_r[30:0], 1'b0};
        y_nxt = {1'b0, y_r[31:1]};
      end else begin
        if (!diff[32]) begin
          acc_nxt = diff[31:0];
          y_nxt   = {y_r[30:0], 1'b1};
        end else begin
          acc_nxt = sh[31:0];
          y_nxt   = {y_r[30:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(bsc_pkg::ALU_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done   = done_r;
  assign result = (op_r == bsc_pkg::ALU_MUL) ? acc_r : y_r;

endmodule

[sv/baro_sensor_compensation.sv]
// Barometric sensor compensation with factory calibration words.
// The input channel takes one word per reading: opcode 0 for a raw temperature,
// opcode 1 for a raw pressure. The output channel gives one word per reading:
// a status and the temperature in 0.1 C or the pressure in Pa.
// Calibration and oversampling are written through the cfg port; the user
// must write them only while idle, as the block itself does not enforce it.
// All multiplies and divides run through one shared unit that multiplies or
// divides one bit per cycle in 32 bit steps, then hands back the result.
// A temperature word takes one multiply and one divide; its result shows on
// the output in the same cycle that the next word can be accepted.
// A pressure word takes ten multiplies and one divide. A pressure word before
// any temperature, and a zero temperature or pressure divisor, end early with
// an error word.
// One reading is worked on at a time; the input stalls until it is finished.
// The finished word sits in an output register, so the next reading may be
// accepted while the receiver stalls the output. A second finished word waits
// in the block, with the input stalled, until the output register is free.
// Reset clears the calibration, the stored temperature and the output valid.
module baro_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [18:0] in_raw_reading,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_value,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] h);
    return {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  bsc_pkg::state_t state_r, state_nxt;
  logic [31:0] cal_ac1_ac2_r, cal_ac3_ac4_r, cal_ac5_ac6_r, cal_b1_b2_r, cal_mc_md_r;
  logic [1:0]  oss_r;
  logic [31:0] temp_r, temp_nxt;
  logic        seen_r, seen_nxt;
  logic        run_r, run_nxt;
  logic [18:0] raw_r, raw_nxt;
  logic [31:0] sq_r, sq_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] b3_r, b3_nxt;
  logic [31:0] p_r, p_nxt;
  logic [31:0] dn_r, dn_nxt;
  logic [31:0] dd_r, dd_nxt;
  logic        neg_r, neg_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [31:0] value_r, value_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [31:0] out_value_r, out_value_nxt;

  bsc_pkg::alu_ctl_t alu_ctl;
  logic [31:0] alu_a, alu_b, alu_res;
  logic        alu_done;

  logic [31:0] b6;
  assign b6 = temp_r - bsc_pkg::B6_OFFSET;

  bsc_serial_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (alu_ctl),
    .opa    (alu_a),
    .opb    (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= bsc_pkg::ST_IDLE;
      cal_ac1_ac2_r <= '0;
      cal_ac3_ac4_r <= '0;
      cal_ac5_ac6_r <= '0;
      cal_b1_b2_r   <= '0;
      cal_mc_md_r   <= '0;
      oss_r         <= '0;
      temp_r        <= '0;
      seen_r        <= 1'b0;
      run_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      temp_r      <= temp_nxt;
      seen_r      <= seen_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bsc_pkg::CFG_AC1_AC2: cal_ac1_ac2_r <= cfg_data;
          bsc_pkg::CFG_AC3_AC4: cal_ac3_ac4_r <= cfg_data;
          bsc_pkg::CFG_AC5_AC6: cal_ac5_ac6_r <= cfg_data;
          bsc_pkg::CFG_B1_B2:   cal_b1_b2_r   <= cfg_data;
          bsc_pkg::CFG_MC_MD:   cal_mc_md_r   <= cfg_data;
          bsc_pkg::CFG_OSS:     oss_r         <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
    raw_r        <= raw_nxt;
    sq_r         <= sq_nxt;
    x_r          <= x_nxt;
    b3_r         <= b3_nxt;
    p_r          <= p_nxt;
    dn_r         <= dn_nxt;
    dd_r         <= dd_nxt;
    neg_r        <= neg_nxt;
    status_r     <= status_nxt;
    value_r      <= value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_comb begin
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] t1, t2, q;
    ac1 = sx16(cal_ac1_ac2_r[31:16]);
    ac2 = sx16(cal_ac1_ac2_r[15:0]);
    ac3 = sx16(cal_ac3_ac4_r[31:16]);
    ac4 = {16'd0, cal_ac3_ac4_r[15:0]};
    ac5 = {16'd0, cal_ac5_ac6_r[31:16]};
    ac6 = {16'd0, cal_ac5_ac6_r[15:0]};
    b1  = sx16(cal_b1_b2_r[31:16]);
    b2  = sx16(cal_b1_b2_r[15:0]);
    mc  = sx16(cal_mc_md_r[31:16]);
    md  = sx16(cal_mc_md_r[15:0]);
    t1  = '0;
    t2  = '0;
    q   = '0;

    state_nxt      = state_r;
    temp_nxt       = temp_r;
    seen_nxt       = seen_r;
    run_nxt        = run_r;
    raw_nxt        = raw_r;
    sq_nxt         = sq_r;
    x_nxt          = x_r;
    b3_nxt         = b3_r;
    p_nxt          = p_r;
    dn_nxt         = dn_r;
    dd_nxt         = dd_r;
    neg_nxt        = neg_r;
    status_nxt     = status_r;
    value_nxt      = value_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    alu_ctl.start  = 1'b0;
    alu_ctl.op     = bsc_pkg::ALU_MUL;
    alu_a          = '0;
    alu_b          = '0;
    in_stall       = (state_r != bsc_pkg::ST_IDLE);

    unique case (state_r)
      bsc_pkg::ST_T_MUL: begin
        alu_a = {16'd0, raw_r[15:0]} - ac6;
        alu_b = ac5;
      end
      bsc_pkg::ST_T_DIV, bsc_pkg::ST_P_DIV: begin
        alu_ctl.op = bsc_pkg::ALU_DIV;
        alu_a      = dn_r;
        alu_b      = dd_r;
      end
      bsc_pkg::ST_P_SQ: begin
        alu_a = b6;
        alu_b = b6;
      end
      bsc_pkg::ST_P_X1: begin
        alu_a = b2;
        alu_b = sq_r;
      end
      bsc_pkg::ST_P_X2: begin
        alu_a = ac2;
        alu_b = b6;
      end
      bsc_pkg::ST_P_X1B: begin
        alu_a = ac3;
        alu_b = b6;
      end
      bsc_pkg::ST_P_X2B: begin
        alu_a = b1;
        alu_b = sq_r;
      end
      bsc_pkg::ST_P_B4: begin
        alu_a = ac4;
        alu_b = x_r;
      end
      bsc_pkg::ST_P_B7: begin
        alu_a = {13'd0, raw_r} - b3_r;
        alu_b = bsc_pkg::P_SCALE >> oss_r;
      end
      bsc_pkg::ST_P_T8: begin
        alu_a = asr(p_r, 8);
        alu_b = asr(p_r, 8);
      end
      bsc_pkg::ST_P_T8C: begin
        alu_a = sq_r;
        alu_b = bsc_pkg::K_T8SQ;
      end
      bsc_pkg::ST_P_X2C: begin
        alu_a = bsc_pkg::K_P;
        alu_b = p_r;
      end
      default: ;
    endcase

    if (state_r != bsc_pkg::ST_IDLE && state_r != bsc_pkg::ST_DONE && !run_r) begin
      alu_ctl.start = 1'b1;
      run_nxt       = 1'b1;
    end

    unique case (state_r)
      bsc_pkg::ST_IDLE: begin
        if (in_valid) begin
          raw_nxt = in_raw_reading;
          if (in_opcode == bsc_pkg::OP_TEMP) begin
            state_nxt = bsc_pkg::ST_T_MUL;
          end else if (!seen_r) begin
            status_nxt = bsc_pkg::STATUS_NO_TEMP;
            value_nxt  = '0;
            state_nxt  = bsc_pkg::ST_DONE;
          end else begin
            state_nxt = bsc_pkg::ST_P_SQ;
          end
        end
      end
      bsc_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_value_nxt  = value_r;
          state_nxt      = bsc_pkg::ST_IDLE;
        end
      end
      default: begin
        if (run_r && alu_done) begin
          run_nxt = 1'b0;
          unique case (state_r)
            bsc_pkg::ST_T_MUL: begin
              t1    = asr(alu_res, 15);
              t2    = t1 + md;
              x_nxt = t1;
              if (t2 == '0) begin
                status_nxt = bsc_pkg::STATUS_DIV_ZERO;
                value_nxt  = '0;
                state_nxt  = bsc_pkg::ST_DONE;
              end else begin
                dn_nxt    = mag({mc[20:0], 11'd0});
                dd_nxt    = mag(t2);
                neg_nxt   = mc[31] ^ t2[31];
                state_nxt = bsc_pkg::ST_T_DIV;
              end
            end
            bsc_pkg::ST_T_DIV: begin
              q          = neg_r ? (32'd0 - alu_res) : alu_res;
              t1         = x_r + q;
              temp_nxt   = t1;
              seen_nxt   = 1'b1;
              status_nxt = bsc_pkg::STATUS_OK;
              value_nxt  = asr(t1 + 32'd8, 4);
              state_nxt  = bsc_pkg::ST_DONE;
            end
            bsc_pkg::ST_P_SQ: begin
              sq_nxt    = asr(alu_res, 12);
              state_nxt = bsc_pkg::ST_P_X1;
            end
            bsc_pkg::ST_P_X1: begin
              x_nxt     = asr(alu_res, 11);
              state_nxt = bsc_pkg::ST_P_X2;
            end
            bsc_pkg::ST_P_X2: begin
              t1        = x_r + asr(alu_res, 11);
              t2        = (({ac1[29:0], 2'b00} + t1) << oss_r) + 32'd2;
              b3_nxt    = asr(t2 + (t2[31] ? 32'd3 : 32'd0), 2);
              state_nxt = bsc_pkg::ST_P_X1B;
            end
            bsc_pkg::ST_P_X1B: begin
              x_nxt     = asr(alu_res, 13);
              state_nxt = bsc_pkg::ST_P_X2B;
            end
            bsc_pkg::ST_P_X2B: begin
              t1        = asr(x_r + asr(alu_res, 16) + 32'd2, 2);
              x_nxt     = t1 + bsc_pkg::X3_BIAS;
              state_nxt = bsc_pkg::ST_P_B4;
            end
            bsc_pkg::ST_P_B4: begin
              t1 = alu_res >> 15;
              if (t1 == '0) begin
                status_nxt = bsc_pkg::STATUS_DIV_ZERO;
                value_nxt  = '0;
                state_nxt  = bsc_pkg::ST_DONE;
              end else begin
                dd_nxt    = t1;
                state_nxt = bsc_pkg::ST_P_B7;
              end
            end
            bsc_pkg::ST_P_B7: begin
              neg_nxt   = alu_res[31];
              dn_nxt    = alu_res[31] ? alu_res : {alu_res[30:0], 1'b0};
              state_nxt = bsc_pkg::ST_P_DIV;
            end
            bsc_pkg::ST_P_DIV: begin
              p_nxt     = neg_r ? {alu_res[30:0], 1'b0} : alu_res;
              state_nxt = bsc_pkg::ST_P_T8;
            end
            bsc_pkg::ST_P_T8: begin
              sq_nxt    = alu_res;
              state_nxt = bsc_pkg::ST_P_T8C;
            end
            bsc_pkg::ST_P_T8C: begin
              x_nxt     = asr(alu_res, 16);
              state_nxt = bsc_pkg::ST_P_X2C;
            end
            bsc_pkg::ST_P_X2C: begin
              t1         = x_r + asr(alu_res, 16) + bsc_pkg::K_ROUND;
              value_nxt  = p_r + asr(t1, 4);
              status_nxt = bsc_pkg::STATUS_OK;
              state_nxt  = bsc_pkg::ST_DONE;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

[sv/bsc_checker.sv]
module bsc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_value
);

  // A stalled result word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled output word changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bsc_pkg::STATUS_OK || out_status == bsc_pkg::STATUS_NO_TEMP ||
                   out_status == bsc_pkg::STATUS_DIV_ZERO))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != bsc_pkg::STATUS_OK |-> out_value == 32'd0)
    else $error("error word carries a nonzero value");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind baro_sensor_compensation bsc_checker u_bsc_checker (.*);
